>>> hw/rtl/mbs_pkg.sv
// Shared types, codes and constants of the multipart boundary scanner.
package mbs_pkg;

  // Character constants of the boundary pattern and the header terminator.
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  // Length of the fixed CR LF dash dash prefix ahead of the token.
  localparam int unsigned PREFIX_LEN = 4;

  // Header detector position that means the detector is inactive.
  localparam logic [2:0] HDR_INACTIVE = 3'd4;
  localparam logic [2:0] HDR_LAST     = 3'd3;

  // Match position loaded by a start item.
  localparam int unsigned START_POS = 2;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TOKEN = 2'd1,
    ACT_BODY  = 2'd2
  } mbs_action_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } mbs_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_CMP,
    S_FRD,
    S_FPUT,
    S_TAIL,
    S_PAY,
    S_END
  } mbs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic tok_wr;
    logic latch_b;
    logic hdr_step;
    logic cmp_step;
    logic flush_init;
    logic flush_read;
    logic flush_put;
    logic tail_step;
    logic pay_put;
    logic end_put;
  } mbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic armed;
    logic tok_empty;
    logic hdr_done;
    logic match;
    logic full;
    logic mp_zero;
    logic in_file;
    logic flush_last;
    logic b_cr;
    logic out_free;
  } mbs_sts_t;

  // Byte of the fixed pattern prefix at positions zero to three.
  function automatic logic [7:0] prefix_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = CHAR_CR;
      2'd1:    r = CHAR_LF;
      default: r = CHAR_DASH;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/mbs_if.sv
// Valid/ready channel interfaces for the scanner's input and result items.
interface mbs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface mbs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [31:0] file_offset;
  logic        last;

  modport source (output valid, output kind, output out_byte, output file_offset,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input file_offset,
                  input last, output ready);
endinterface

>>> hw/rtl/mbs_ram.sv
// Generic single-port-write, registered-read RAM.
module mbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 56,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hw/rtl/mbs_datapath.sv
// Datapath of the scanner: token memory, match and header state, output register.
module mbs_datapath import mbs_pkg::*; #(
  parameter int unsigned MAX_TOKEN = 56
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mbs_cmd_t    cmd_i,
  output mbs_sts_t    sts_o,
  input  logic [7:0]  in_byte_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] out_offset_o,
  output logic        out_last_o
);
  localparam int unsigned CNT_W = $clog2(MAX_TOKEN + 1);
  localparam int unsigned POS_W = $clog2(MAX_TOKEN + PREFIX_LEN + 1);
  localparam int unsigned AW    = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
  localparam logic [POS_W-1:0] PRE_LEN = POS_W'(PREFIX_LEN);

  logic [CNT_W-1:0] tok_cnt_q;
  logic             armed_q;
  logic [POS_W-1:0] mp_q;
  logic [2:0]       hdr_q;
  logic             in_file_q;
  logic [31:0]      off_q;
  logic [POS_W-1:0] k_q;
  logic             out_valid_q;
  logic [7:0]       b_q;
  logic             out_kind_q;
  logic [7:0]       out_byte_q;
  logic [31:0]      out_off_q;
  logic             out_last_q;

  logic [POS_W-1:0] plen;
  logic [POS_W-1:0] mp_eff;
  logic [POS_W-1:0] mp_inc;
  logic [POS_W-1:0] k_inc;
  logic [POS_W-1:0] mp_idx;
  logic [POS_W-1:0] k_idx;
  logic             tok_full;
  logic             tok_empty;
  logic             hdr_active;
  logic             hdr_hit;
  logic             hdr_done;
  logic [2:0]       hdr_next;
  logic             b_cr;
  logic [7:0]       ram_rdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       pat_mp;
  logic [7:0]       pat_k;
  logic             match;
  logic             full;
  logic             flush_last;
  logic             out_free;
  logic             tail_emit;
  logic             load;

  assign tok_full   = (tok_cnt_q == CNT_W'(MAX_TOKEN));
  assign tok_empty  = (tok_cnt_q == '0);
  assign plen       = POS_W'(tok_cnt_q) + PRE_LEN;
  assign mp_eff     = (!tok_empty && (mp_q >= plen)) ? '0 : mp_q;
  assign mp_inc     = mp_q + POS_W'(1);
  assign k_inc      = k_q + POS_W'(1);
  assign mp_idx     = mp_eff - PRE_LEN;
  assign k_idx      = k_q - PRE_LEN;

  assign b_cr       = (b_q == CHAR_CR);
  assign hdr_active = (hdr_q < HDR_INACTIVE);
  assign hdr_hit    = (b_q == (hdr_q[0] ? CHAR_LF : CHAR_CR));
  assign hdr_done   = hdr_active && hdr_hit && (hdr_q == HDR_LAST);
  assign hdr_next   = hdr_hit ? (hdr_q + 3'd1) : (b_cr ? 3'd1 : 3'd0);

  // The memory is read only at token positions, which are always written.
  assign ram_re    = (cmd_i.hdr_step && (mp_eff >= PRE_LEN)) ||
                     (cmd_i.flush_read && (k_q >= PRE_LEN));
  assign ram_raddr = cmd_i.flush_read ? k_idx[AW-1:0] : mp_idx[AW-1:0];

  mbs_ram #(
    .WIDTH (8),
    .DEPTH (MAX_TOKEN)
  ) u_tok_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tok_wr && !tok_full),
    .waddr_i (tok_cnt_q[AW-1:0]),
    .wdata_i (in_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign pat_mp     = (mp_q >= PRE_LEN) ? ram_rdata : prefix_byte(mp_q[1:0]);
  assign pat_k      = (k_q >= PRE_LEN) ? ram_rdata : prefix_byte(k_q[1:0]);
  assign match      = (b_q == pat_mp);
  assign full       = (mp_inc == plen);
  assign flush_last = (k_inc == mp_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign tail_emit  = cmd_i.tail_step && in_file_q && !b_cr;
  assign load       = cmd_i.flush_put || tail_emit || cmd_i.pay_put || cmd_i.end_put;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_cnt_q   <= '0;
      armed_q     <= 1'b0;
      mp_q        <= '0;
      hdr_q       <= HDR_INACTIVE;
      in_file_q   <= 1'b0;
      off_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        tok_cnt_q <= '0;
        armed_q   <= 1'b1;
        mp_q      <= POS_W'(START_POS);
        hdr_q     <= HDR_INACTIVE;
        in_file_q <= 1'b0;
        off_q     <= '0;
      end
      if (cmd_i.tok_wr && !tok_full) begin
        tok_cnt_q <= tok_cnt_q + CNT_W'(1);
      end
      if (cmd_i.hdr_step) begin
        if (hdr_done) begin
          hdr_q     <= HDR_INACTIVE;
          in_file_q <= 1'b1;
          off_q     <= '0;
          mp_q      <= '0;
        end else begin
          if (hdr_active) begin
            hdr_q <= hdr_next;
          end
          mp_q <= mp_eff;
        end
      end
      if (cmd_i.cmp_step && match) begin
        if (full) begin
          mp_q      <= '0;
          in_file_q <= 1'b0;
          hdr_q     <= '0;
        end else begin
          mp_q <= mp_inc;
        end
      end
      if (cmd_i.flush_init) begin
        k_q <= '0;
      end
      if (cmd_i.flush_put) begin
        k_q   <= k_inc;
        off_q <= off_q + 32'd1;
      end
      if (cmd_i.tail_step) begin
        mp_q <= b_cr ? POS_W'(1) : '0;
      end
      if (tail_emit || cmd_i.pay_put) begin
        off_q <= off_q + 32'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_b) begin
      b_q <= in_byte_i;
    end
    if (load) begin
      out_kind_q <= cmd_i.end_put ? KIND_END : KIND_DATA;
      out_off_q  <= off_q;
      if (cmd_i.end_put) begin
        out_byte_q <= 8'd0;
        out_last_q <= 1'b1;
      end else if (cmd_i.flush_put) begin
        out_byte_q <= pat_k;
        out_last_q <= flush_last && b_cr;
      end else begin
        out_byte_q <= b_q;
        out_last_q <= 1'b1;
      end
    end
  end

  assign sts_o.armed      = armed_q;
  assign sts_o.tok_empty  = tok_empty;
  assign sts_o.hdr_done   = hdr_done;
  assign sts_o.match      = match;
  assign sts_o.full       = full;
  assign sts_o.mp_zero    = (mp_q == '0);
  assign sts_o.in_file    = in_file_q;
  assign sts_o.flush_last = flush_last;
  assign sts_o.b_cr       = b_cr;
  assign sts_o.out_free   = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_byte_o   = out_byte_q;
  assign out_offset_o = out_off_q;
  assign out_last_o   = out_last_q;
endmodule

>>> hw/rtl/mbs_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module mbs_ctrl import mbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  output logic       in_ready_o,
  input  mbs_sts_t   sts_i,
  output mbs_cmd_t   cmd_o
);
  mbs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (mbs_action_e'(action_i))
            ACT_START: cmd_o.start  = 1'b1;
            ACT_TOKEN: cmd_o.tok_wr = 1'b1;
            ACT_BODY: begin
              if (sts_i.armed) begin
                cmd_o.latch_b = 1'b1;
                state_d       = S_HDR;
              end
            end
            default: ;
          endcase
        end
      end
      S_HDR: begin
        cmd_o.hdr_step = 1'b1;
        if (sts_i.hdr_done) begin
          state_d = S_IDLE;
        end else if (sts_i.tok_empty) begin
          state_d = sts_i.in_file ? S_PAY : S_IDLE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.match) begin
          state_d = (sts_i.full && sts_i.in_file) ? S_END : S_IDLE;
        end else if (sts_i.in_file && !sts_i.mp_zero) begin
          cmd_o.flush_init = 1'b1;
          state_d          = S_FRD;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_FRD: begin
        cmd_o.flush_read = 1'b1;
        state_d          = S_FPUT;
      end
      S_FPUT: begin
        if (sts_i.out_free) begin
          cmd_o.flush_put = 1'b1;
          state_d         = sts_i.flush_last ? S_TAIL : S_FRD;
        end
      end
      S_TAIL: begin
        if (sts_i.b_cr || !sts_i.in_file || sts_i.out_free) begin
          cmd_o.tail_step = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_PAY: begin
        if (sts_i.out_free) begin
          cmd_o.pay_put = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.end_put = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/multipart_boundary_scanner.sv
// Top level of the multipart boundary scanner.
//
// The scanner reads a multipart body one item at a time. A start item arms it and clears
// the boundary token; token items append bytes to the token (bytes beyond MAX_TOKEN are
// dropped); body items are scanned against the pattern CR LF dash dash token, starting
// at the first dash. After each boundary a CR LF CR LF detector finds the end of the part
// header, and the file bytes that follow are sent out as payload items with a running
// offset. Bytes that partly match the boundary are held back; a mismatch releases them
// as payload, and a complete boundary closes the file with an end-of-file item that
// carries the file length. Start, token and unused items are handled in the idle state,
// as is a body item while the scanner is not armed. An armed body item is latched and
// passes the header step, where it ends when it ends a part header or when the token is
// empty and no file is open; with an empty token and an open file it gives a payload item,
// and otherwise it passes the compare step, which extends or completes a match, closes an
// open file with an end-of-file item, or breaks a match and goes on to the tail step after
// releasing each held byte by a read of the registered token memory and an output step.
// Every result also waits for the output register to be free, so a stalled receiver holds
// the scanner. While a result waits in the output register the next item is still taken,
// and a further result only waits for that register to drain.
module multipart_boundary_scanner import mbs_pkg::*; #(
  parameter int unsigned MAX_TOKEN = 56
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbs_in_if.sink    req_i,
  mbs_out_if.source res_o
);
  mbs_cmd_t cmd;
  mbs_sts_t sts;

  // The controller decides what happens to each item in which cycle.
  mbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .action_i   (req_i.action),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the token memory, the matcher state and the output register.
  mbs_datapath #(
    .MAX_TOKEN (MAX_TOKEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_byte_i    (req_i.in_byte),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_kind_o   (res_o.kind),
    .out_byte_o   (res_o.out_byte),
    .out_offset_o (res_o.file_offset),
    .out_last_o   (res_o.last)
  );
endmodule

>>> hw/rtl/mbs_checker.sv
// Port-level checks on the scanner and their attachment to the top level.
module mbs_checker import mbs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [7:0]  out_byte_i,
  input logic [31:0] out_offset_i,
  input logic        out_last_i
);
  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its offset.
  a_off_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_offset_i))
    else $error("result offset changed while stalled");

  // An end-of-file item carries a zero byte and closes its item's results.
  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_END) |-> (out_byte_i == 8'd0) && out_last_i)
    else $error("malformed end-of-file item");

  // Start, token and unused items are finished in the cycle they are taken.
  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i != ACT_BODY) |=> in_ready_i)
    else $error("scanner busy after a non-body item");
endmodule

bind multipart_boundary_scanner mbs_checker u_mbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .in_action_i  (req_i.action),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_kind_i   (res_o.kind),
  .out_byte_i   (res_o.out_byte),
  .out_offset_i (res_o.file_offset),
  .out_last_i   (res_o.last)
);
